[hdl/day_night_light_cycle_core_macros.svh]
// Assertion macros for the day/night light cycle core checker.
// Depends on nothing; the checker file includes it.
`ifndef DAY_NIGHT_LIGHT_CYCLE_CORE_MACROS_SVH
`define DAY_NIGHT_LIGHT_CYCLE_CORE_MACROS_SVH
// Same-cycle implication, disabled while reset is held.
`define DNLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define DNLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Next-cycle implication that is checked during reset as well.
`define DNLC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/dnlc_pkg.sv]
// Shared types, constants and functions of the day/night light cycle core.
// No dependencies; all files but the macros header and dnlc_checker import it.
package dnlc_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int ANGLE_ITER_DEF = 16;
    localparam int CFG_IDX_W      = 4;
    localparam int DIV_STEPS      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAWN_END     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_END      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUSK_END     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DAWN_LENGTH  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUSK_LENGTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOURS      = 4'd7;

    localparam logic [31:0] RST_CYCLE_LENGTH = 32'd78643200;
    localparam logic [31:0] RST_HALF_PERIOD  = 32'd39321600;
    localparam logic [31:0] RST_DAWN_END     = 32'd6553600;
    localparam logic [31:0] RST_DAY_END      = 32'd39321600;
    localparam logic [31:0] RST_DUSK_END     = 32'd45875200;
    localparam logic [31:0] RST_DAWN_LENGTH  = 32'd6553600;
    localparam logic [31:0] RST_DUSK_LENGTH  = 32'd6553600;
    localparam logic [47:0] RST_COLOURS      = 48'hFFFFFF202040;

    // CORDIC gain compensation, Q2.30.
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic [16:0] F_ONE = 17'd65536;

    typedef enum logic [3:0] {
        S_IDLE, S_WRAP, S_MOD, S_PSTART, S_PDIV, S_CSTART, S_ROT,
        S_BSTART, S_BDIV, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_DAWN, PH_DAY, PH_DUSK, PH_NIGHT
    } t_phase;

    // Arctangent of 2^-i in 2^-32 turn units.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        begin
            unique case (idx)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12e4051d;
                5'd2:  v = 32'h09fb385b;
                5'd3:  v = 32'h051111d4;
                5'd4:  v = 32'h028b0d43;
                5'd5:  v = 32'h0145d7e1;
                5'd6:  v = 32'h00a2f61e;
                5'd7:  v = 32'h00517c55;
                5'd8:  v = 32'h0028be53;
                5'd9:  v = 32'h00145f2e;
                5'd10: v = 32'h000a2f98;
                5'd11: v = 32'h000517cc;
                5'd12: v = 32'h00028be6;
                5'd13: v = 32'h000145f3;
                5'd14: v = 32'h0000a2f9;
                5'd15: v = 32'h0000517c;
                5'd16: v = 32'h000028be;
                5'd17: v = 32'h0000145f;
                5'd18: v = 32'h00000a2f;
                5'd19: v = 32'h00000517;
                5'd20: v = 32'h0000028b;
                5'd21: v = 32'h00000145;
                5'd22: v = 32'h000000a2;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

    // Round a Q2.30 value to Q1.15, negate on request, saturate.
    function automatic logic [15:0] to_q15(input logic signed [33:0] v, input logic neg);
        logic signed [34:0] s;
        logic signed [19:0] r;
        begin
            s = 35'(v) + 35'sd16384;
            r = s[34:15];
            if (neg) begin
                r = -r;
            end
            if (r > 20'sd32767) begin
                r = 20'sd32767;
            end else if (r < -20'sd32768) begin
                r = -20'sd32768;
            end
            return r[15:0];
        end
    endfunction

endpackage

[hdl/dnlc_fdiv.sv]
// Bit-serial restoring fraction divider: quot = floor(num * 2^31 / den), num < 2*den.
// Depends on dnlc_pkg. One quotient bit per cycle.
module dnlc_fdiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    import dnlc_pkg::*;

    logic [33:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [31:0] r_quot;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [33:0] cand;
    logic        ge;

    always_comb begin
        cand  = (r_cnt == 6'd0) ? r_rem : {r_rem[32:0], 1'b0};
        ge    = cand >= {2'b00, r_den};
        n_rem = ge ? (cand - {2'b00, r_den}) : cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[30:0], ge};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

[hdl/dnlc_cordic.sv]
// Iterative rotation CORDIC: cosine and sine of a 32-bit turn fraction in Q1.15.
// Depends on dnlc_pkg. One rotation per cycle.
module dnlc_cordic #(
    parameter int ANGLE_ITERATIONS = dnlc_pkg::ANGLE_ITER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_p,
    output logic        o_done,
    output logic [15:0] o_cos,
    output logic [15:0] o_sin
);
    import dnlc_pkg::*;

    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]         r_cnt;
    logic               r_busy, r_done, r_neg;
    logic signed [33:0] xs, ys, at;
    logic               fold;
    logic [31:0]        pf;

    always_comb begin
        fold = i_p[31] != i_p[30];
        pf   = fold ? (i_p + 32'h80000000) : i_p;
        xs   = r_x >>> r_cnt;
        ys   = r_y >>> r_cnt;
        at   = signed'({2'b00, atan_turn(r_cnt)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= CORDIC_START;
                r_y    <= '0;
                r_z    <= 34'(signed'(pf));
                r_neg  <= fold;
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(ANGLE_ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = to_q15(r_x, r_neg);
    assign o_sin  = to_q15(r_y, r_neg);
endmodule

[hdl/day_night_light_cycle_core.sv]
// Top level of the day/night light cycle core: time update, sun angle and light blend.
// Depends on dnlc_pkg, dnlc_fdiv and dnlc_cordic.
//
//  channel  | direction | contents
//  s_axis   | in        | time_step request, 24 bits
//  m_axis   | out       | sun_cos, sun_sin, night_weight, light_red/green/blue
//  cfg      | in        | register index and write data, always ready
//
// Requests are taken only in the idle state, so a new one waits until the last has passed
// its output step; a second division is added when a dawn or dusk blend factor is below one.
// The gap is set by the bit-serial remainder loop, the serial divider that serves the
// sun angle and the blend factor, and the iterative CORDIC.
// Reset is synchronous and active low; it restores the configuration registers and zeroes the time.
// A finished result waits in the output register while the m_axis side stalls; the next
// request is still taken, and its result waits in the last step until that register frees.
module day_night_light_cycle_core #(
    parameter int TIME_BITS        = dnlc_pkg::TIME_BITS_DEF,
    parameter int ANGLE_ITERATIONS = dnlc_pkg::ANGLE_ITER_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // time_step
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // sun_cos, sun_sin, night_weight, light_red, light_green, light_blue
    output logic [95:0]                    m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dnlc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [47:0]                    i_cfg_data
);
    import dnlc_pkg::*;

    // Common compare width of the time and the 32-bit registers.
    localparam int CW  = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int MCW = $clog2(TIME_BITS + 1);

    // Configuration registers.
    logic [31:0] r_day_span, r_half, r_rise_stop, r_day_end, r_fall_stop;
    logic [31:0] r_rise_span, r_fall_span;
    logic [47:0] r_colours;

    t_state r_state, n_state;
    logic [TIME_BITS-1:0] r_tod, n_tod;
    logic [23:0]          r_step;
    logic [TIME_BITS-1:0] r_tsh;
    logic [33:0]          r_mrem, n_mrem;
    logic [MCW-1:0]       r_mcnt;
    t_phase               r_phase, n_phase;
    logic [31:0]          r_d, n_d, r_len, n_len;
    logic [16:0]          r_f;
    logic                 r_ovalid;
    logic [95:0]          r_odata, n_odata;

    logic        div_start, div_done;
    logic [33:0] div_num;
    logic [31:0] div_den, div_quot;
    logic        cor_start, cor_done;
    logic [15:0] cor_cos, cor_sin;
    logic        load_out, need_div;
    logic [31:0] h_eff;
    logic [CW:0] sum, cl;
    logic [CW-1:0] te, dusk_off;
    logic [33:0] mcand;

    // Time update: add the step, fold back by one cycle length, wrap to TIME_BITS.
    always_comb begin
        sum   = (CW + 1)'(r_tod) + (CW + 1)'(r_step);
        cl    = (CW + 1)'(r_day_span);
        if (sum > cl) begin
            sum = sum - cl;
        end
        n_tod = sum[TIME_BITS-1:0];
        h_eff = (r_half == 32'd0) ? 32'd1 : r_half;
    end

    // Remainder of the time by twice the half period, one time bit per cycle.
    always_comb begin
        mcand  = {r_mrem[32:0], r_tsh[TIME_BITS-1]};
        n_mrem = (mcand >= {1'b0, h_eff, 1'b0}) ? (mcand - {1'b0, h_eff, 1'b0}) : mcand;
    end

    // Phase selection from the new time; the tests run in dawn, day, dusk order.
    always_comb begin
        te       = CW'(r_tod);
        dusk_off = te - CW'(r_day_end);
        n_d      = te[31:0];
        n_len    = (r_rise_span == 32'd0) ? 32'd1 : r_rise_span;
        if (te < CW'(r_rise_stop)) begin
            n_phase = PH_DAWN;
        end else if (te < CW'(r_day_end)) begin
            n_phase = PH_DAY;
        end else if (te < CW'(r_fall_stop)) begin
            n_phase = PH_DUSK;
            n_d     = dusk_off[31:0];
            n_len   = (r_fall_span == 32'd0) ? 32'd1 : r_fall_span;
        end else begin
            n_phase = PH_NIGHT;
        end
        need_div = ((r_phase == PH_DAWN) || (r_phase == PH_DUSK)) && (r_d < r_len);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (s_axis_tvalid) n_state = S_WRAP;
            S_WRAP:   n_state = S_MOD;
            S_MOD:    if (r_mcnt == MCW'(TIME_BITS - 1)) n_state = S_PSTART;
            S_PSTART: n_state = S_PDIV;
            S_PDIV:   if (div_done) n_state = S_CSTART;
            S_CSTART: n_state = S_ROT;
            S_ROT:    if (cor_done) n_state = S_BSTART;
            S_BSTART: n_state = need_div ? S_BDIV : S_OUT;
            S_BDIV:   if (div_done) n_state = S_OUT;
            S_OUT:    if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_axis_tready = r_state == S_IDLE;
        cor_start     = r_state == S_CSTART;
        div_start     = (r_state == S_PSTART) || ((r_state == S_BSTART) && need_div);
        load_out      = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);
        if (r_state == S_PSTART) begin
            div_num = r_mrem;
            div_den = h_eff;
        end else begin
            div_num = {2'b00, r_d};
            div_den = r_len;
        end
    end

    // Result word: colour blend and night weight by phase.
    always_comb begin
        logic [7:0]  dc, nc;
        logic [25:0] acc;
        logic [15:0] ch [3];
        logic [15:0] night;
        logic [16:0] inv;
        inv = F_ONE - r_f;
        acc = '0;
        for (int c = 0; c < 3; c++) begin
            dc = r_colours[40 - 8 * c +: 8];
            nc = r_colours[16 - 8 * c +: 8];
            unique case (r_phase)
                PH_DAWN: begin
                    acc   = 26'(nc * inv) + 26'(dc * r_f);
                    ch[c] = acc[23:8];
                end
                PH_DAY:   ch[c] = {dc, 8'd0};
                PH_DUSK: begin
                    acc   = 26'(dc * inv) + 26'(nc * r_f);
                    ch[c] = acc[23:8];
                end
                default:  ch[c] = {nc, 8'd0};
            endcase
        end
        unique case (r_phase)
            PH_DAWN: night = inv[16] ? 16'hFFFF : inv[15:0];
            PH_DAY:  night = 16'd0;
            PH_DUSK: night = r_f[16] ? 16'hFFFF : r_f[15:0];
            default: night = 16'hFFFF;
        endcase
        n_odata = {ch[2], ch[1], ch[0], night, cor_sin, cor_cos};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tod       <= '0;
            r_mcnt      <= '0;
            r_ovalid    <= 1'b0;
            r_day_span  <= RST_CYCLE_LENGTH;
            r_half      <= RST_HALF_PERIOD;
            r_rise_stop <= RST_DAWN_END;
            r_day_end   <= RST_DAY_END;
            r_fall_stop <= RST_DUSK_END;
            r_rise_span <= RST_DAWN_LENGTH;
            r_fall_span <= RST_DUSK_LENGTH;
            r_colours   <= RST_COLOURS;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CYCLE_LENGTH: r_day_span  <= i_cfg_data[31:0];
                    REG_HALF_PERIOD:  r_half      <= i_cfg_data[31:0];
                    REG_DAWN_END:     r_rise_stop <= i_cfg_data[31:0];
                    REG_DAY_END:      r_day_end   <= i_cfg_data[31:0];
                    REG_DUSK_END:     r_fall_stop <= i_cfg_data[31:0];
                    REG_DAWN_LENGTH:  r_rise_span <= i_cfg_data[31:0];
                    REG_DUSK_LENGTH:  r_fall_span <= i_cfg_data[31:0];
                    REG_COLOURS:      r_colours   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && s_axis_tvalid) begin
                r_step <= s_axis_tdata;
            end
            if (r_state == S_WRAP) begin
                r_tod  <= n_tod;
                r_tsh  <= n_tod;
                r_mrem <= '0;
                r_mcnt <= '0;
            end
            if (r_state == S_MOD) begin
                r_mrem  <= n_mrem;
                r_tsh   <= {r_tsh[TIME_BITS-2:0], 1'b0};
                r_mcnt  <= r_mcnt + MCW'(1);
                r_phase <= n_phase;
                r_d     <= n_d;
                r_len   <= n_len;
            end
            if (r_state == S_BSTART && !need_div) begin
                r_f <= F_ONE;
            end
            if (r_state == S_BDIV && div_done) begin
                r_f <= div_quot[31:15];
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
                r_odata  <= n_odata;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    dnlc_fdiv u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    dnlc_cordic #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_p     (div_quot),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

[hdl/dnlc_checker.sv]
// Port-level checker of the day/night light cycle core, bound to the top level.
// Depends on day_night_light_cycle_core_macros.svh.
`include "day_night_light_cycle_core_macros.svh"
module dnlc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    `DNLC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `DNLC_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
    `DNLC_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result too early")
    `DNLC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n, !m_axis_tvalid, "result valid after reset")
endmodule

bind day_night_light_cycle_core dnlc_checker u_dnlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[verif/day_night_light_cycle_core_checker.sv]
// Checker for the day/night light cycle core: watches the config, input and result channels,
// predicts each result and compares it field by field. Depends on dnlc_pkg.
module day_night_light_cycle_core_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step_valid,
    input  logic                           i_step_ready,
    input  logic [23:0]                    i_step_data,
    input  logic                           i_light_valid,
    input  logic                           i_light_ready,
    input  logic [95:0]                    i_light_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [dnlc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [47:0]                    i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import dnlc_pkg::*;

    localparam int ITERS = ANGLE_ITER_DEF;
    localparam longint unsigned TIME_MASK = (64'd1 << TIME_BITS_DEF) - 64'd1;

    // Lowest field in the lowest bits, as on the result bus.
    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
        logic [15:0] night;
        logic [15:0] sin_q15;
        logic [15:0] cos_q15;
    } light_t;

    localparam logic [31:0] ATAN_STEP [24] = '{
        32'h20000000, 32'h12e4051d, 32'h09fb385b, 32'h051111d4,
        32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
        32'h0028be53, 32'h00145f2e, 32'h000a2f98, 32'h000517cc,
        32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c,
        32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
        32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051
    };

    longint unsigned day_span, half_per, rise_stop, day_end, fall_stop, rise_span, fall_span;
    logic [47:0]     palette;
    longint unsigned day_time;
    light_t          light_q[$];
    int              n_err;

    assign o_fail_count = n_err + o_pending;

    function automatic logic [15:0] round_q15(longint v, bit neg);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (neg) r = -r;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic longint unsigned ramp(longint unsigned d, longint unsigned len);
        longint unsigned l;
        l = (len == 0) ? 1 : len;
        if (d >= l) return 65536;
        return (d << 16) / l;
    endfunction

    function automatic logic [15:0] fade(logic [7:0] a, logic [7:0] b, longint unsigned f);
        longint unsigned v;
        v = (longint'(a) * (65536 - f) + longint'(b) * f) >> 8;
        return v[15:0];
    endfunction

    // Advances the time of day by one step and returns the light it leads to.
    function automatic light_t next_light(logic [23:0] step);
        longint unsigned t, h, r, f, nw;
        logic [31:0]     p;
        longint          x, y, z, xs, ys;
        bit              neg;
        logic [7:0]      dc [3];
        logic [7:0]      nc [3];
        light_t          res;
        logic [15:0]     ch [3];

        t = day_time + longint'(step);
        if (t > day_span) t -= day_span;
        t &= TIME_MASK;
        day_time = t;

        // Sun angle as a turn fraction, folded into the right half plane.
        h = (half_per == 0) ? 1 : half_per;
        r = t % (h * 2);
        p = 32'((r << 31) / h);
        neg = 0;
        if (p[31] != p[30]) begin
            p += 32'h80000000;
            neg = 1;
        end
        z = longint'($signed(p));
        x = 652032874;
        y = 0;
        for (int i = 0; i < ITERS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(ATAN_STEP[i]);
            end else begin
                x += ys; y -= xs; z += longint'(ATAN_STEP[i]);
            end
        end
        res.cos_q15 = round_q15(x, neg);
        res.sin_q15 = round_q15(y, neg);

        for (int c = 0; c < 3; c++) begin
            dc[c] = palette[40-8*c +: 8];
            nc[c] = palette[16-8*c +: 8];
        end
        if (t < rise_stop) begin
            f = ramp(t, rise_span);
            nw = 65536 - f;
            if (nw > 65535) nw = 65535;
            for (int c = 0; c < 3; c++) ch[c] = fade(nc[c], dc[c], f);
        end else if (t < day_end) begin
            nw = 0;
            for (int c = 0; c < 3; c++) ch[c] = {dc[c], 8'd0};
        end else if (t < fall_stop) begin
            f = ramp(t - day_end, fall_span);
            nw = (f > 65535) ? 65535 : f;
            for (int c = 0; c < 3; c++) ch[c] = fade(dc[c], nc[c], f);
        end else begin
            nw = 65535;
            for (int c = 0; c < 3; c++) ch[c] = {nc[c], 8'd0};
        end
        res.night = nw[15:0];
        res.red   = ch[0];
        res.green = ch[1];
        res.blue  = ch[2];
        return res;
    endfunction

    always @(posedge i_clk) begin
        light_t want, got;
        if (!i_rst_n) begin
            day_span  <= RST_CYCLE_LENGTH;
            half_per  <= RST_HALF_PERIOD;
            rise_stop <= RST_DAWN_END;
            day_end   <= RST_DAY_END;
            fall_stop <= RST_DUSK_END;
            rise_span <= RST_DAWN_LENGTH;
            fall_span <= RST_DUSK_LENGTH;
            palette   <= RST_COLOURS;
            day_time  = 0;
            light_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CYCLE_LENGTH: day_span  <= i_cfg_data[31:0];
                    REG_HALF_PERIOD:  half_per  <= i_cfg_data[31:0];
                    REG_DAWN_END:     rise_stop <= i_cfg_data[31:0];
                    REG_DAY_END:      day_end   <= i_cfg_data[31:0];
                    REG_DUSK_END:     fall_stop <= i_cfg_data[31:0];
                    REG_DAWN_LENGTH:  rise_span <= i_cfg_data[31:0];
                    REG_DUSK_LENGTH:  fall_span <= i_cfg_data[31:0];
                    REG_COLOURS:      palette   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_light_valid && i_light_ready) begin
                got = i_light_data;
                if (light_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    n_err++;
                end else begin
                    want = light_q.pop_front();
                    if (got.cos_q15 !== want.cos_q15)
                        $display("%0t: sun_cos expected %h actual %h",
                                 $time, want.cos_q15, got.cos_q15);
                    if (got.sin_q15 !== want.sin_q15)
                        $display("%0t: sun_sin expected %h actual %h",
                                 $time, want.sin_q15, got.sin_q15);
                    if (got.night !== want.night)
                        $display("%0t: night_weight expected %h actual %h",
                                 $time, want.night, got.night);
                    if (got.red !== want.red)
                        $display("%0t: light_red expected %h actual %h",
                                 $time, want.red, got.red);
                    if (got.green !== want.green)
                        $display("%0t: light_green expected %h actual %h",
                                 $time, want.green, got.green);
                    if (got.blue !== want.blue)
                        $display("%0t: light_blue expected %h actual %h",
                                 $time, want.blue, got.blue);
                    if (got !== want) n_err++;
                end
            end
            if (i_step_valid && i_step_ready) light_q.push_back(next_light(i_step_data));
            o_pending <= light_q.size();
        end
    end

    initial n_err = 0;
endmodule

[verif/day_night_light_cycle_core_tb.sv]
// Testbench top for the day/night light cycle core: drives time steps, register writes
// and result backpressure. Depends on dnlc_pkg, the core and its checker.
module day_night_light_cycle_core_tb;
    import dnlc_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int ITEMS_PER_SET = 240;
    localparam int SETTINGS_N    = 8;
    localparam int DRAIN_CYCLES  = 200;
    localparam int LONG_HOLD     = 3000;
    // Indexes above the last register are not mapped and must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = REG_COLOURS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [95:0]          m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [47:0]          i_cfg_data = '0;

    int  fail_count, pending;
    int  cycles = 0;
    bit  no_gaps = 0;
    bit  hold_request = 0;
    int  steps_sent = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    day_night_light_cycle_core u_dut (.*);

    day_night_light_cycle_core_checker u_chk (
        .i_clk, .i_rst_n,
        .i_step_valid(s_axis_tvalid), .i_step_ready(s_axis_tready), .i_step_data(s_axis_tdata),
        .i_light_valid(m_axis_tvalid), .i_light_ready(m_axis_tready),
        .i_light_data(m_axis_tdata),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The run is cut off here if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: a random stall before each result unless gaps are off, and one long hold-off
    // on request so that the block backs up and stops taking time steps.
    initial begin
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            wait_n = no_gaps ? 0 : $urandom_range(7, 0);
            if (hold_request) begin
                wait_n = LONG_HOLD;
                hold_request = 0;
            end
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Sends one time step request, after a random gap unless gaps are off.
    task automatic send_step(logic [23:0] step);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(7, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= step;
        do @(posedge i_clk); while (!s_axis_tready);
        steps_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // 32-bit registers get random upper data bits, which the block must drop.
    function automatic logic [47:0] word(logic [31:0] v);
        return {16'($urandom), v};
    endfunction

    // Waits for every result, then lets the last computation settle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Picks a register set: all ones, all zeros (zero divisors, tiny wrap point), zero
    // divisors alone, unordered phase ends, or random ordered phases.
    task automatic load_settings(int set_no);
        logic [31:0] cl, e0, e1, e2, tmp;
        cl = $urandom_range(32'h1000_0000, 32'h0010_0000);
        e0 = $urandom_range(cl, 0);
        e1 = $urandom_range(cl, 0);
        e2 = $urandom_range(cl, 0);
        if (set_no != 4) begin
            if (e0 > e1) begin tmp = e0; e0 = e1; e1 = tmp; end
            if (e1 > e2) begin tmp = e1; e1 = e2; e2 = tmp; end
            if (e0 > e1) begin tmp = e0; e0 = e1; e1 = tmp; end
        end else begin
            tmp = e0; e0 = e2; e2 = tmp;
        end
        case (set_no)
            1: begin
                write_reg(REG_CYCLE_LENGTH, '1);
                write_reg(REG_HALF_PERIOD, '1);
                write_reg(REG_DAWN_END, '1);
                write_reg(REG_DAY_END, '1);
                write_reg(REG_DUSK_END, '1);
                write_reg(REG_DAWN_LENGTH, '1);
                write_reg(REG_DUSK_LENGTH, '1);
                write_reg(REG_COLOURS, '1);
            end
            2: begin
                write_reg(REG_CYCLE_LENGTH, word(32'd1));
                write_reg(REG_HALF_PERIOD, word(32'd0));
                write_reg(REG_DAWN_END, word(32'd0));
                write_reg(REG_DAY_END, word(32'd0));
                write_reg(REG_DUSK_END, word(32'd0));
                write_reg(REG_DAWN_LENGTH, word(32'd0));
                write_reg(REG_DUSK_LENGTH, word(32'd0));
                write_reg(REG_COLOURS, '0);
            end
            default: begin
                write_reg(REG_CYCLE_LENGTH, word(cl));
                write_reg(REG_HALF_PERIOD, word(set_no == 3 ? 32'd0 : $urandom_range(cl, 1)));
                write_reg(REG_DAWN_END, word(e0));
                write_reg(REG_DAY_END, word(e1));
                write_reg(REG_DUSK_END, word(e2));
                write_reg(REG_DAWN_LENGTH,
                          word(set_no == 3 ? 32'd0 : $urandom_range(cl >> 3, 1)));
                write_reg(REG_DUSK_LENGTH,
                          word(set_no == 3 ? 32'd0 : $urandom_range(cl >> 3, 1)));
                write_reg(REG_COLOURS, {16'($urandom), 32'($urandom)});
            end
        endcase
        // A write to an unmapped index must leave every register alone.
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
                  {16'($urandom), 32'($urandom)});
    endtask

    initial begin
        logic [23:0] step;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed steps at the reset settings: zero and full-scale steps, a walk through
        // dawn, day, dusk and night, and a step past the end of the day.
        send_step(24'd0);
        send_step(24'hFFFFFF);
        send_step(24'd0);
        send_step(24'd1);
        for (int k = 0; k < 12; k++) send_step(24'd6553600);
        send_step(24'hFFFFFF);
        send_step(24'hFFFFFF);
        send_step(24'h000001);
        send_step(24'h800000);
        send_step(24'h7FFFFF);
        settle();

        for (int s = 1; s <= SETTINGS_N; s++) begin
            // The special and random sets first, then back to the reset values once.
            if (s == SETTINGS_N) begin
                write_reg(REG_CYCLE_LENGTH, {16'd0, RST_CYCLE_LENGTH});
                write_reg(REG_HALF_PERIOD, {16'd0, RST_HALF_PERIOD});
                write_reg(REG_DAWN_END, {16'd0, RST_DAWN_END});
                write_reg(REG_DAY_END, {16'd0, RST_DAY_END});
                write_reg(REG_DUSK_END, {16'd0, RST_DUSK_END});
                write_reg(REG_DAWN_LENGTH, {16'd0, RST_DAWN_LENGTH});
                write_reg(REG_DUSK_LENGTH, {16'd0, RST_DUSK_LENGTH});
                write_reg(REG_COLOURS, RST_COLOURS);
            end else begin
                load_settings(s);
            end
            no_gaps = (s == 6);
            if (s == 5) hold_request = 1;
            for (int k = 0; k < ITEMS_PER_SET; k++) begin
                case ($urandom_range(3, 0))
                    0:       step = 24'($urandom_range(255, 0));
                    1:       step = 24'($urandom_range(24'hFFFFFF, 24'hF00000));
                    default: step = 24'($urandom);
                endcase
                send_step(step);
                // One pause in the middle of a set until every result is back.
                if (s == 3 && k == ITEMS_PER_SET / 2) begin
                    s_axis_tvalid <= 1'b0;
                    do @(posedge i_clk); while (pending != 0);
                end
            end
            settle();
        end

        $display("Covered %0d time steps over %0d register sets, including zero divisors,",
                 steps_sent, SETTINGS_N + 1);
        $display("unordered phase ends, extreme values, unmapped writes and long stalls.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
